// ===== rtl/core/rgld_pkg.sv =====
// Package: item types, decode phases and constants of the Rice gap list decoder.
`timescale 1ns / 1ps
package rgld_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned ParamMax   = 31;

  typedef struct packed {
    logic [31:0] stream_word;
    logic        word_is_first;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        run_last;
    logic        list_done;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_PARAM = 2'd1,
    PH_QUOT  = 2'd2,
    PH_LOW   = 2'd3
  } phase_t;

endpackage

// ===== rtl/core/rice_gap_list_decoder_core.sv =====
// Rice gap list decoder: bit-serial scan of 32-bit stream words into list values.
//
// A word marked first loads the first list value in its accept cycle and hands it
// over once the output is free; with an empty list nothing is handed over. Any
// other word is loaded in its accept cycle while a list is open (else it is
// dropped) and then shifted out one bit per cycle, unless the output side stalls,
// to the end of the word or until the list ends inside it; the last value of the
// word, when it has one, is then handed over before the next word is accepted.
// Values are built in one running 32-bit accumulator: each quotient zero adds 2^k
// and each set low bit adds its weight. The last value of a word is held one stage
// so that it can carry run_last; at most 16 values are returned per word.
// value_count is sampled when a first word arrives.
`timescale 1ns / 1ps
module rice_gap_list_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rgld_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rgld_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam int unsigned IdxW = $clog2(rgld_pkg::WordBits);
  localparam int unsigned CntW = $clog2(rgld_pkg::MaxResults) + 1;
  localparam int unsigned ZcW  = $clog2(rgld_pkg::ParamMax + 1) + 1;

  logic [31:0]        value_count;
  rgld_pkg::phase_t   phase, phase_next;
  logic               scan_active;
  logic [31:0]        word_sr;
  logic [IdxW-1:0]    bit_idx;
  logic [ZcW-1:0]     zcnt;
  logic [4:0]         rice_param;
  logic [4:0]         taken;
  logic [31:0]        acc;
  logic [31:0]        remaining;
  logic [CntW-1:0]    emit_cnt;
  logic               pend_valid;
  logic [31:0]        pend_value;
  logic               pend_done;

  logic               in_fire, out_free, bit_in, finish, last_value, keep, stall, scan_go;
  logic               scan_end, out_load;
  logic [4:0]         taken_inc;
  logic [31:0]        addend, acc_sum;
  logic               cin;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !scan_active && !pend_valid;
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign bit_in     = word_sr[0];
  assign taken_inc  = taken + 5'd1;
  assign last_value = (remaining == 32'd1);
  assign keep       = (emit_cnt < CntW'(rgld_pkg::MaxResults));

  // Step datapath: value completion, accumulator addend
  always_comb begin
    finish = 1'b0;
    addend = '0;
    cin    = 1'b0;
    unique case (phase)
      rgld_pkg::PH_QUOT: begin
        if (bit_in) begin
          finish = (rice_param == 5'd0);
        end else begin
          addend = 32'd1 << rice_param;
        end
      end
      rgld_pkg::PH_LOW: begin
        if (bit_in) addend = 32'd1 << taken;
        finish = (taken_inc == rice_param);
      end
      default: ;
    endcase
    cin = finish;
  end

  assign acc_sum  = acc + addend + {31'd0, cin};
  assign stall    = finish && keep && pend_valid && !out_free;
  assign scan_go  = scan_active && !stall;
  assign scan_end = scan_go &&
                    ((bit_idx == IdxW'(rgld_pkg::WordBits - 1)) || (finish && last_value));
  assign out_load = (scan_go && finish && keep && pend_valid) ||
                    (!scan_active && pend_valid && out_free);

  function automatic logic cfg_le1(input logic [31:0] v);
    cfg_le1 = (v[31:1] == 31'd0);
  endfunction

  // Next phase
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      if (in_item.word_is_first) begin
        phase_next = (cfg_le1(value_count)) ? rgld_pkg::PH_WAIT : rgld_pkg::PH_PARAM;
      end
    end else if (scan_go) begin
      unique case (phase)
        rgld_pkg::PH_PARAM: if (bit_in) phase_next = rgld_pkg::PH_QUOT;
        rgld_pkg::PH_QUOT: begin
          if (bit_in) begin
            if (finish) phase_next = last_value ? rgld_pkg::PH_WAIT : rgld_pkg::PH_QUOT;
            else        phase_next = rgld_pkg::PH_LOW;
          end
        end
        rgld_pkg::PH_LOW: begin
          if (finish) phase_next = last_value ? rgld_pkg::PH_WAIT : rgld_pkg::PH_QUOT;
        end
        default: phase_next = rgld_pkg::PH_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      phase       <= rgld_pkg::PH_WAIT;
      scan_active <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      emit_cnt    <= '0;
      bit_idx     <= '0;
      zcnt        <= '0;
      rice_param  <= '0;
      taken       <= '0;
      acc         <= '0;
      remaining   <= '0;
    end else begin
      phase <= phase_next;
      if (cfg_valid) value_count <= cfg_data;
      out_valid <= out_load || (out_valid && !out_ready);

      if (in_fire) begin
        if (in_item.word_is_first) begin
          zcnt       <= '0;
          taken      <= '0;
          rice_param <= '0;
          acc        <= in_item.stream_word;
          if (value_count == 32'd0) begin
            remaining <= '0;
          end else begin
            remaining  <= value_count - 32'd1;
            pend_valid <= 1'b1;
            pend_value <= in_item.stream_word;
            pend_done  <= (value_count == 32'd1);
            emit_cnt   <= CntW'(1);
          end
        end else if (phase != rgld_pkg::PH_WAIT) begin
          scan_active <= 1'b1;
          word_sr     <= in_item.stream_word;
          bit_idx     <= '0;
          emit_cnt    <= '0;
        end
      end else if (scan_go) begin
        word_sr <= word_sr >> 1;
        bit_idx <= bit_idx + IdxW'(1);
        if (scan_end) scan_active <= 1'b0;
        acc <= acc_sum;
        unique case (phase)
          rgld_pkg::PH_PARAM: begin
            if (bit_in) begin
              rice_param <= (zcnt > ZcW'(rgld_pkg::ParamMax)) ?
                            5'(rgld_pkg::ParamMax) : zcnt[4:0];
              zcnt <= '0;
            end else if (zcnt <= ZcW'(rgld_pkg::ParamMax)) begin
              zcnt <= zcnt + ZcW'(1);
            end
          end
          rgld_pkg::PH_LOW: taken <= finish ? 5'd0 : taken_inc;
          default: ;
        endcase
        if (finish) begin
          remaining <= remaining - 32'd1;
          if (keep) begin
            emit_cnt   <= emit_cnt + CntW'(1);
            pend_valid <= 1'b1;
            pend_value <= acc_sum;
            pend_done  <= last_value;
            if (pend_valid) begin
              out_item.value     <= pend_value;
              out_item.run_last  <= 1'b0;
              out_item.list_done <= pend_done;
            end
          end
        end
      end else if (!scan_active && pend_valid && out_free) begin
        pend_valid         <= 1'b0;
        out_item.value     <= pend_value;
        out_item.run_last  <= 1'b1;
        out_item.list_done <= pend_done;
      end
    end
  end

endmodule
